// ===== rtl/core/c3lbf_pkg.sv =====
// ----------------------------------------------------------------------------
// c3lbf_pkg
// Types, register codes and helpers of the 3x3 line buffer convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c3lbf_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 11;
    localparam int TAPS       = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_TOP = 3'd0,
        CFG_COEFF_MID = 3'd1,
        CFG_COEFF_BOT = 3'd2,
        CFG_WIDTH     = 3'd3,
        CFG_HEIGHT    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic emit;
        logic last;
        logic top;
        logic bot;
        logic left;
        logic right;
    } t_tap_ctl;

    function automatic logic [PIX_W-1:0] mul_lo8(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [2*PIX_W-1:0] p;
        p = a * b;
        return p[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/c3lbf_ram.sv =====
// ----------------------------------------------------------------------------
// c3lbf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module c3lbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/conv3x3_line_buffer_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_filter
// 3x3 convolution over a raster pixel stream with two line buffers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_pixel, i_fill
//  out       output     o_out_valid / i_out_ready   o_out_pixel, o_frame_end
//  cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One word per cycle while o_in_ready is high; results pass stages A, B, C.
//  The rate is set by one read-modify-write of the line memory per word.
//  An 8-entry result queue absorbs output stalls; input ready drops once
//  8 results are outstanding. The config port is always ready.
//  Reset restores the register defaults and empties the pipeline and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_line_buffer_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_pixel,
    input  wire logic        i_fill,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_out_pixel,
    output logic             o_frame_end,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int NW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int BW       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
    localparam int RST_W    = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int RST_H    = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int RST_NPIX = RST_W * RST_H;
    localparam int PW       = c3lbf_pkg::PIX_W;
    localparam int NT       = c3lbf_pkg::TAPS;
    localparam int FD       = c3lbf_pkg::FIFO_DEPTH;
    localparam int FAW      = c3lbf_pkg::FIFO_AW;
    localparam int FCW      = c3lbf_pkg::FIFO_CW;

    // configuration
    logic [c3lbf_pkg::COEF_W-1:0] r_coef [NT];
    logic [WW-1:0]                r_eff_w;
    logic [HW-1:0]                r_eff_h;
    logic [NW-1:0]                r_npix;

    logic [c3lbf_pkg::SIZE_W-1:0] cfg_size;
    logic [WW-1:0]                clamp_w;
    logic [HW-1:0]                clamp_h;
    logic [WW-1:0]                n_eff_w;
    logic [HW-1:0]                n_eff_h;
    logic [WW+HW-1:0]             n_npix;
    logic                         size_we;

    // frame counters
    logic [CW-1:0] r_cp;
    logic [BW-1:0] r_beat;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;

    logic                 in_acc;
    logic                 out_acc;
    logic [PW-1:0]        newp;
    logic [WW-1:0]        cp_inc;
    logic [WW-1:0]        col_inc;
    logic [HW-1:0]        row_inc;
    logic                 col_end;
    logic                 row_end;
    c3lbf_pkg::t_tap_ctl  acc_ctl;

    // stage A: memory read in flight
    logic                 r_a_vld;
    logic [CW-1:0]        r_a_cp;
    logic [PW-1:0]        r_a_newp;
    c3lbf_pkg::t_tap_ctl  r_a_ctl;
    logic                 r_fwd;
    logic [2*PW-1:0]      r_fwd_data;
    logic [2*PW-1:0]      ram_rdata;
    logic [2*PW-1:0]      ent;
    logic [2*PW-1:0]      wr_data;

    // stage B: window updated
    logic [PW-1:0]        r_win [NT][NT];
    logic                 r_b_vld;
    c3lbf_pkg::t_tap_ctl  r_b_ctl;

    // stage C: products
    logic [PW-1:0]        r_c_prod [NT][NT];
    logic                 r_c_vld;
    logic                 r_c_last;
    logic [NT-1:0]        row_ok;
    logic [NT-1:0]        col_ok;
    logic [PW-1:0]        sum;

    // result queue
    logic [PW-1:0]        r_fifo_pix  [FD];
    logic                 r_fifo_last [FD];
    logic [FAW-1:0]       r_wp;
    logic [FAW-1:0]       r_rp;
    logic [FCW-1:0]       r_cnt;
    logic [FCW-1:0]       r_outst;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_outst < FCW'(FD));
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != '0);
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_pixel = r_fifo_pix[r_rp];
    assign o_frame_end = r_fifo_last[r_rp];

    // configuration decode
    always_comb begin
        cfg_size = i_cfg_data[c3lbf_pkg::SIZE_W-1:0];
        if (cfg_size == '0) begin
            clamp_w = WW'(1);
        end else if (32'(cfg_size) > MAX_WIDTH) begin
            clamp_w = WW'(MAX_WIDTH);
        end else begin
            clamp_w = WW'(cfg_size);
        end
        if (cfg_size == '0) begin
            clamp_h = HW'(1);
        end else if (32'(cfg_size) > MAX_HEIGHT) begin
            clamp_h = HW'(MAX_HEIGHT);
        end else begin
            clamp_h = HW'(cfg_size);
        end
        n_eff_w = r_eff_w;
        n_eff_h = r_eff_h;
        size_we = 1'b0;
        if (i_cfg_valid) begin
            case (c3lbf_pkg::t_cfg_idx'(i_cfg_index))
                c3lbf_pkg::CFG_WIDTH: begin
                    n_eff_w = clamp_w;
                    size_we = 1'b1;
                end
                c3lbf_pkg::CFG_HEIGHT: begin
                    n_eff_h = clamp_h;
                    size_we = 1'b1;
                end
                default: begin
                end
            endcase
        end
        n_npix = n_eff_w * n_eff_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NT; r++) begin
                r_coef[r] <= '0;
            end
            r_eff_w <= WW'(RST_W);
            r_eff_h <= HW'(RST_H);
            r_npix  <= NW'(RST_NPIX);
        end else if (i_cfg_valid) begin
            case (c3lbf_pkg::t_cfg_idx'(i_cfg_index))
                c3lbf_pkg::CFG_COEFF_TOP: r_coef[0] <= i_cfg_data;
                c3lbf_pkg::CFG_COEFF_MID: r_coef[1] <= i_cfg_data;
                c3lbf_pkg::CFG_COEFF_BOT: r_coef[2] <= i_cfg_data;
                default: begin
                end
            endcase
            r_eff_w <= n_eff_w;
            r_eff_h <= n_eff_h;
            r_npix  <= n_npix[NW-1:0];
        end
    end

    // accept side
    always_comb begin
        newp    = (i_fill || (r_beat >= BW'(r_npix))) ? '0 : i_pixel;
        cp_inc  = WW'(r_cp) + 1'b1;
        col_inc = WW'(r_out_col) + 1'b1;
        row_inc = HW'(r_out_row) + 1'b1;
        col_end = (col_inc >= r_eff_w);
        row_end = (row_inc >= r_eff_h);
        acc_ctl.emit  = (r_beat > BW'(r_eff_w));
        acc_ctl.last  = row_end && col_end;
        acc_ctl.top   = (r_out_row != '0);
        acc_ctl.bot   = !row_end;
        acc_ctl.left  = (r_out_col != '0);
        acc_ctl.right = !col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp      <= '0;
            r_beat    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (size_we) begin
            r_cp      <= '0;
            r_beat    <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (in_acc) begin
            if (acc_ctl.emit && acc_ctl.last) begin
                r_cp      <= '0;
                r_beat    <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_cp   <= (cp_inc >= r_eff_w) ? '0 : cp_inc[CW-1:0];
                r_beat <= r_beat + 1'b1;
                if (acc_ctl.emit) begin
                    if (col_end) begin
                        r_out_col <= '0;
                        r_out_row <= row_inc[RW-1:0];
                    end else begin
                        r_out_col <= col_inc[CW-1:0];
                    end
                end
            end
        end
    end

    // line memory: low byte older line, high byte newer line
    c3lbf_ram #(
        .WIDTH(2 * PW),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (r_a_vld),
        .i_waddr(r_a_cp),
        .i_wdata(wr_data),
        .i_re   (in_acc),
        .i_raddr(r_cp),
        .o_rdata(ram_rdata)
    );

    assign ent     = r_fwd ? r_fwd_data : ram_rdata;
    assign wr_data = {r_a_newp, ent[2*PW-1:PW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_a_vld <= in_acc;
            r_b_vld <= r_a_vld && r_a_ctl.emit;
            r_c_vld <= r_b_vld;
            if (in_acc) begin
                r_fwd <= r_a_vld && (r_a_cp == r_cp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_cp     <= r_cp;
            r_a_newp   <= newp;
            r_a_ctl    <= acc_ctl;
            r_fwd_data <= wr_data;
        end
    end

    // shift window, load new column
    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            for (int r = 0; r < NT; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= ent[PW-1:0];
            r_win[1][2] <= ent[2*PW-1:PW];
            r_win[2][2] <= r_a_newp;
            r_b_ctl     <= r_a_ctl;
        end
    end

    // masked products, low byte only
    assign row_ok = {r_b_ctl.bot, 1'b1, r_b_ctl.top};
    assign col_ok = {r_b_ctl.right, 1'b1, r_b_ctl.left};

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            for (int r = 0; r < NT; r++) begin
                for (int c = 0; c < NT; c++) begin
                    r_c_prod[r][c] <= (row_ok[r] && col_ok[c])
                        ? c3lbf_pkg::mul_lo8(r_win[r][c], r_coef[r][PW*c +: PW])
                        : '0;
                end
            end
            r_c_last <= r_b_ctl.last;
        end
    end

    always_comb begin
        sum = '0;
        for (int r = 0; r < NT; r++) begin
            for (int c = 0; c < NT; c++) begin
                sum = sum + r_c_prod[r][c];
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (r_c_vld) begin
            r_fifo_pix[r_wp]  <= sum;
            r_fifo_last[r_wp] <= r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_cnt   <= '0;
            r_outst <= '0;
        end else begin
            if (r_c_vld) begin
                r_wp <= r_wp + 1'b1;
            end
            if (out_acc) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt   <= r_cnt + FCW'(r_c_vld) - FCW'(out_acc);
            r_outst <= r_outst + FCW'(in_acc && acc_ctl.emit) - FCW'(out_acc);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/c3lbf_checker.sv =====
// ----------------------------------------------------------------------------
// c3lbf_checker
// Port-level checks of the 3x3 line buffer convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

module c3lbf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_out_pixel,
    input wire logic        o_frame_end,
    input wire logic        o_cfg_ready
);

    logic in_acc;

    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_pixel) && $stable(o_frame_end))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready && o_cfg_ready)
        else $error("not idle after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_acc, 4))
        else $error("output word without input word four cycles earlier");

endmodule

bind conv3x3_line_buffer_filter c3lbf_checker u_c3lbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_pixel(o_out_pixel),
    .o_frame_end(o_frame_end),
    .o_cfg_ready(o_cfg_ready)
);

`default_nettype wire
